// ===== design/usb_ep0_control_responder_core_defines.svh =====
// ----------------------------------------------------------------------------
// USB endpoint-0 responder assertion macros
// Shared property macros for the endpoint-0 control responder.
// ----------------------------------------------------------------------------
`ifndef USB_EP0_CONTROL_RESPONDER_CORE_DEFINES_SVH
`define USB_EP0_CONTROL_RESPONDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UEP0_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UEP0_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/uep0_pkg.sv =====
// ----------------------------------------------------------------------------
// uep0_pkg
// Types, codes and descriptor lengths for the endpoint-0 control responder.
// ----------------------------------------------------------------------------
package uep0_pkg;

    localparam int MAX_PACKET_DEF = 32;

    localparam logic [7:0] REPORT_LENGTH_RESET = 8'd30;

    // Event kinds
    typedef enum logic [1:0] {
        KIND_SETUP     = 2'd0,
        KIND_OUT_DONE  = 2'd1,
        KIND_IN_DONE   = 2'd2,
        KIND_BUS_RESET = 2'd3
    } kind_t;

    // What was armed on the IN endpoint
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_DATA = 2'd1,
        ACT_ZLP  = 2'd2
    } action_t;

    // Descriptor source
    typedef enum logic [2:0] {
        SRC_DEVICE   = 3'd0,
        SRC_CONFIG   = 3'd1,
        SRC_LANGUAGE = 3'd2,
        SRC_STRING   = 3'd3,
        SRC_REPORT   = 3'd4
    } source_t;

    // Setup request codes
    localparam logic [6:0] RTYPE_CLASS_IFACE     = 7'h21;
    localparam logic [7:0] REQ_HID_SET_IDLE      = 8'h0A;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

    // Descriptor types
    localparam logic [7:0] DESC_DEVICE = 8'h01;
    localparam logic [7:0] DESC_CONFIG = 8'h02;
    localparam logic [7:0] DESC_STRING = 8'h03;
    localparam logic [7:0] DESC_REPORT = 8'h22;

    // Descriptor lengths
    localparam logic [7:0] LEN_DEVICE   = 8'd18;
    localparam logic [7:0] LEN_CONFIG   = 8'd34;
    localparam logic [7:0] LEN_LANGUAGE = 8'd4;
    localparam logic [7:0] STRING_COUNT = 8'd5;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [7:0]  value_high;
        logic [7:0]  value_low;
        logic [15:0] length_requested;
        logic [9:0]  rx_size;
    } ep0_item_t;

    typedef struct packed {
        logic       address_pending;
        logic [6:0] stored_address;
        logic [6:0] configuration_value;
        logic [7:0] bytes_remaining;
        logic [7:0] send_offset;
        source_t    current_source;
        logic [2:0] current_string;
        logic       zero_packet_owed;
        logic       awaiting_status;
    } ep0_state_t;

    typedef struct packed {
        action_t    action;
        source_t    source;
        logic [2:0] string_number;
        logic [7:0] byte_offset;
        logic [6:0] packet_length;
        logic       apply_address;
        logic [6:0] device_address;
        logic [6:0] active_configuration;
        logic       status_seen;
    } ep0_result_t;

    // Fixed string descriptor lengths, index 1 to 5
    function automatic logic [7:0] string_length(input logic [2:0] idx);
        logic [7:0] len;
        case (idx)
            3'd1:    len = 8'd6;
            3'd2:    len = 8'd20;
            3'd3:    len = 8'd32;
            3'd4:    len = 8'd32;
            3'd5:    len = 8'd12;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

    // Clip a descriptor length to wLength
    function automatic logic [7:0] clip_len(input logic [7:0] n, input logic [15:0] wlen);
        logic [7:0] r;
        r = ({8'h00, n} <= wlen) ? n : wlen[7:0];
        return r;
    endfunction

endpackage

// ===== design/usb_ep0_control_responder_core.sv =====
// ----------------------------------------------------------------------------
// usb_ep0_control_responder_core
// Endpoint-0 control responder for a USB HID device: descriptor transfers,
// address, configuration, SET_IDLE and status stage tracking.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Contents
//  --------  --------------------  ---------------------------------------------
//  in        in_valid / in_stall   one event word: kind, setup fields, rx_size
//  out       out_valid / out_stall one result word per event: armed packet,
//                                  address, configuration, status seen
//  cfg       cfg_wr_en             report_length written from cfg_wr_data
//
//  Every event yields exactly one result word; it passes from the input
//  register to the result register and leaves at an edge without out_stall.
//  A new event is taken every cycle unless out_stall holds a result; the rate
//  is set by one pass of uep0_step between the input and result registers.
//  When out_stall holds a finished result, the input register still fills
//  once; in_stall rises only when both stages are occupied.
//  rst_n clears valid flags and transfer state; report_length resets to 30.
//
module usb_ep0_control_responder_core #(
    parameter int MAX_PACKET = uep0_pkg::MAX_PACKET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [7:0]  value_high,
    input  logic [7:0]  value_low,
    input  logic [15:0] length_requested,
    input  logic [9:0]  rx_size,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [2:0]  source,
    output logic [2:0]  string_number,
    output logic [7:0]  byte_offset,
    output logic [6:0]  packet_length,
    output logic        apply_address,
    output logic [6:0]  device_address,
    output logic [6:0]  active_configuration,
    output logic        status_seen,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import uep0_pkg::*;

`include "usb_ep0_control_responder_core_defines.svh"

    // Input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    ep0_item_t   item_reg;
    logic        take_in;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    ep0_result_t result_reg;
    ep0_result_t result_next;
    logic        advance;

    // Endpoint state and the one register
    ep0_state_t  state_reg;
    ep0_state_t  state_next;
    logic [7:0]  report_length_reg;

    // Terms for the checks at the end
    logic        xfer_empty;
    logic        xfer_done;
    logic        data_out;
    logic        pkt_len_ok;
    logic        addr_in_done;
    logic        addr_done;

    // Advance the event into the result stage unless a result is stuck there
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    uep0_step #(
        .MAX_PACKET (MAX_PACKET)
    ) u_step (
        .item          (item_reg),
        .state_cur     (state_reg),
        .report_length (report_length_reg),
        .state_nxt     (state_next),
        .result        (result_next)
    );

    // Control flags and endpoint state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Report descriptor length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_length_reg <= REPORT_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            report_length_reg <= cfg_wr_data;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.kind             <= kind_t'(kind);
            item_reg.request_type     <= request_type;
            item_reg.request_code     <= request_code;
            item_reg.value_high       <= value_high;
            item_reg.value_low        <= value_low;
            item_reg.length_requested <= length_requested;
            item_reg.rx_size          <= rx_size;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign action               = result_reg.action;
    assign source               = result_reg.source;
    assign string_number        = result_reg.string_number;
    assign byte_offset          = result_reg.byte_offset;
    assign packet_length        = result_reg.packet_length;
    assign apply_address        = result_reg.apply_address;
    assign device_address       = result_reg.device_address;
    assign active_configuration = result_reg.active_configuration;
    assign status_seen          = result_reg.status_seen;

    assign xfer_empty   = (state_reg.bytes_remaining == 8'd0);
    assign xfer_done    = xfer_empty && !state_reg.zero_packet_owed;
    assign data_out     = out_valid_reg && (result_reg.action == ACT_DATA);
    assign pkt_len_ok   = (result_reg.packet_length != 7'd0)
                          && ({1'b0, result_reg.packet_length} <= 8'(MAX_PACKET));
    assign addr_in_done = advance && (item_reg.kind == KIND_IN_DONE)
                          && state_reg.address_pending;
    assign addr_done    = !state_reg.address_pending && result_reg.apply_address;

    // A trailing zero-length packet is owed only once all data is out
    `UEP0_ASSERT_NOW(a_zlp_after_data, state_reg.zero_packet_owed, xfer_empty, "ZLP owed early")

    // The status stage is awaited only once the transfer is fully sent
    `UEP0_ASSERT_NOW(a_status_after_send, state_reg.awaiting_status, xfer_done, "early status")

    // An armed data packet is never empty and never above max packet size
    `UEP0_ASSERT_NOW(a_packet_size, data_out, pkt_len_ok, "data packet size out of range")

    // An IN completion consumes a pending address
    `UEP0_ASSERT_NEXT(a_address_applied, addr_in_done, addr_done, "pending address not applied")

endmodule

// ===== design/uep0_step.sv =====
// ----------------------------------------------------------------------------
// uep0_step
// Next-state and result logic for one endpoint-0 event.
// ----------------------------------------------------------------------------
module uep0_step #(
    parameter int MAX_PACKET = uep0_pkg::MAX_PACKET_DEF
) (
    input  uep0_pkg::ep0_item_t   item,
    input  uep0_pkg::ep0_state_t  state_cur,
    input  logic [7:0]            report_length,
    output uep0_pkg::ep0_state_t  state_nxt,
    output uep0_pkg::ep0_result_t result
);
    import uep0_pkg::*;

    localparam logic [7:0] MaxPkt = 8'(MAX_PACKET);

    typedef struct packed {
        ep0_state_t st;
        action_t    action;
        source_t    source;
        logic [2:0] string_number;
        logic [7:0] byte_offset;
        logic [6:0] packet_length;
    } pkt_t;

    // Arm the next chunk of the transfer, or the trailing zero-length packet
    function automatic pkt_t next_packet(input ep0_state_t s);
        pkt_t       p;
        logic [7:0] send;
        p        = '0;
        p.action = ACT_NONE;
        p.source = SRC_DEVICE;
        p.st     = s;
        send     = (s.bytes_remaining <= MaxPkt) ? s.bytes_remaining : MaxPkt;
        if (s.bytes_remaining != 8'd0)
        begin
            if (s.bytes_remaining == MaxPkt)
            begin
                p.st.zero_packet_owed = 1'b1;
            end
            p.action             = ACT_DATA;
            p.source             = s.current_source;
            p.string_number      = (s.current_source == SRC_STRING) ? s.current_string : 3'd0;
            p.byte_offset        = s.send_offset;
            p.packet_length      = send[6:0];
            p.st.send_offset     = s.send_offset + send;
            p.st.bytes_remaining = s.bytes_remaining - send;
        end
        else if (s.zero_packet_owed)
        begin
            p.st.zero_packet_owed = 1'b0;
            p.action              = ACT_ZLP;
        end
        if (p.st.bytes_remaining == 8'd0 && !p.st.zero_packet_owed)
        begin
            p.st.awaiting_status = 1'b1;
        end
        return p;
    endfunction

    always_comb
    begin
        ep0_state_t st;
        pkt_t       pk;
        logic       desc_ok;
        source_t    desc_src;
        logic [2:0] desc_str;
        logic [7:0] desc_size;

        st        = state_cur;
        pk        = '0;
        desc_ok   = 1'b0;
        desc_src  = SRC_DEVICE;
        desc_str  = 3'd0;
        desc_size = 8'd0;

        result               = '0;
        result.action        = ACT_NONE;
        result.source        = SRC_DEVICE;

        unique case (item.kind)
            KIND_SETUP:
            begin
                if (item.request_type[6:0] == RTYPE_CLASS_IFACE)
                begin
                    if (item.request_code == REQ_HID_SET_IDLE)
                    begin
                        result.action = ACT_ZLP;
                    end
                end
                else
                begin
                    unique case (item.request_code)
                        REQ_GET_DESCRIPTOR:
                        begin
                            unique case (item.value_high)
                                DESC_DEVICE:
                                begin
                                    desc_ok   = 1'b1;
                                    desc_src  = SRC_DEVICE;
                                    desc_size = clip_len(LEN_DEVICE, item.length_requested);
                                end
                                DESC_CONFIG:
                                begin
                                    desc_ok   = 1'b1;
                                    desc_src  = SRC_CONFIG;
                                    desc_size = clip_len(LEN_CONFIG, item.length_requested);
                                end
                                DESC_STRING:
                                begin
                                    if (item.value_low == 8'd0)
                                    begin
                                        desc_ok   = 1'b1;
                                        desc_src  = SRC_LANGUAGE;
                                        desc_size = clip_len(LEN_LANGUAGE,
                                                             item.length_requested);
                                    end
                                    else if (item.value_low <= STRING_COUNT)
                                    begin
                                        // Strings ignore wLength
                                        desc_ok   = 1'b1;
                                        desc_src  = SRC_STRING;
                                        desc_str  = item.value_low[2:0];
                                        desc_size = string_length(item.value_low[2:0]);
                                    end
                                end
                                DESC_REPORT:
                                begin
                                    desc_ok   = 1'b1;
                                    desc_src  = SRC_REPORT;
                                    desc_size = clip_len(report_length, item.length_requested);
                                end
                                default:
                                begin
                                    desc_ok = 1'b0;
                                end
                            endcase
                            if (desc_ok)
                            begin
                                st.current_source   = desc_src;
                                st.current_string   = desc_str;
                                st.send_offset      = 8'd0;
                                st.awaiting_status  = 1'b0;
                                st.bytes_remaining  = desc_size;
                                st.zero_packet_owed = (desc_size == 8'd0);
                                pk                  = next_packet(st);
                                st                  = pk.st;
                                result.action        = pk.action;
                                result.source        = pk.source;
                                result.string_number = pk.string_number;
                                result.byte_offset   = pk.byte_offset;
                                result.packet_length = pk.packet_length;
                            end
                        end
                        REQ_SET_ADDRESS:
                        begin
                            st.stored_address  = item.value_low[6:0];
                            st.address_pending = 1'b1;
                            result.action      = ACT_ZLP;
                        end
                        REQ_SET_CONFIGURATION:
                        begin
                            st.configuration_value = item.value_low[6:0];
                            result.action          = ACT_ZLP;
                        end
                        default:
                        begin
                            result.action = ACT_NONE;
                        end
                    endcase
                end
            end
            KIND_OUT_DONE:
            begin
                if (item.rx_size == 10'd0 && state_cur.awaiting_status)
                begin
                    st.awaiting_status = 1'b0;
                    result.status_seen = 1'b1;
                end
            end
            KIND_IN_DONE:
            begin
                if (state_cur.address_pending)
                begin
                    st.address_pending   = 1'b0;
                    result.apply_address = 1'b1;
                end
                pk                   = next_packet(st);
                st                   = pk.st;
                result.action        = pk.action;
                result.source        = pk.source;
                result.string_number = pk.string_number;
                result.byte_offset   = pk.byte_offset;
                result.packet_length = pk.packet_length;
            end
            KIND_BUS_RESET:
            begin
                st.address_pending     = 1'b0;
                st.stored_address      = 7'd0;
                st.configuration_value = 7'd0;
            end
        endcase

        result.device_address       = st.stored_address;
        result.active_configuration = st.configuration_value;
        state_nxt                   = st;
    end

endmodule

// ===== tb/sv/tb_usb_ep0_control_responder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_ep0_control_responder_core
// Self-checking bench for the endpoint-0 control responder. Host events are
// queued by the stimulus process and fed through the input handshake in
// bursts. Each accepted event runs through a behavioral predictor of the
// responder. Result words are compared field by field, in order, against
// the predicted replies while the result side stalls on its own pattern.
// The report descriptor length is changed between phases, with the
// responder idle.
// ----------------------------------------------------------------------------
module tb_usb_ep0_control_responder_core;

    import uep0_pkg::*;

    localparam int PKT = MAX_PACKET_DEF;

    // bmRequestType values used by a well-behaved host
    localparam logic [7:0] RT_DEV_TO_HOST = 8'h80;
    localparam logic [7:0] RT_HOST_TO_DEV = 8'h00;
    localparam logic [7:0] RT_CLASS_OUT   = 8'h21;
    localparam logic [7:0] RT_CLASS_IN    = 8'hA1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [7:0]  request_type = '0;
    logic [7:0]  request_code = '0;
    logic [7:0]  value_high = '0;
    logic [7:0]  value_low = '0;
    logic [15:0] length_requested = '0;
    logic [9:0]  rx_size = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic [2:0]  source;
    logic [2:0]  string_number;
    logic [7:0]  byte_offset;
    logic [6:0]  packet_length;
    logic        apply_address;
    logic [6:0]  device_address;
    logic [6:0]  active_configuration;
    logic        status_seen;

    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    usb_ep0_control_responder_core #(
        .MAX_PACKET (PKT)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .request_type         (request_type),
        .request_code         (request_code),
        .value_high           (value_high),
        .value_low            (value_low),
        .length_requested     (length_requested),
        .rx_size              (rx_size),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .action               (action),
        .source               (source),
        .string_number        (string_number),
        .byte_offset          (byte_offset),
        .packet_length        (packet_length),
        .apply_address        (apply_address),
        .device_address       (device_address),
        .active_configuration (active_configuration),
        .status_seen          (status_seen),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data)
    );

    // Host events waiting to be driven; the head is the word on the bus
    // while in_valid is high.
    ep0_item_t   host_events_q[$];
    // Predicted result words, oldest first
    ep0_result_t expected_replies_q[$];

    // Predictor state: endpoint-0 control state and the report length register
    ep0_state_t  ctl = '0;
    logic [7:0]  report_len_model = REPORT_LENGTH_RESET;

    int unsigned errors = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // The watchdog allows ten times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clip a descriptor length to what the host asked for (wLength).
    function automatic logic [7:0] fit_to_request(input logic [7:0] n, input logic [15:0] wlen);
        if (wlen < {8'd0, n})
            return wlen[7:0];
        return n;
    endfunction

    // Arm the next chunk of the running transfer, or the owed zero-length
    // packet, and flag the status stage once everything has gone out.
    function automatic void arm_next_packet(inout ep0_result_t r);
        logic [7:0] chunk;
        if (ctl.bytes_remaining != 8'd0)
        begin
            if (ctl.bytes_remaining == PKT)
                ctl.zero_packet_owed = 1'b1;
            chunk = (ctl.bytes_remaining < PKT) ? ctl.bytes_remaining : 8'(PKT);
            r.action        = ACT_DATA;
            r.source        = ctl.current_source;
            r.string_number = (ctl.current_source == SRC_STRING) ? ctl.current_string : 3'd0;
            r.byte_offset   = ctl.send_offset;
            r.packet_length = chunk[6:0];
            ctl.send_offset     = ctl.send_offset + chunk;
            ctl.bytes_remaining = ctl.bytes_remaining - chunk;
        end
        else if (ctl.zero_packet_owed)
        begin
            ctl.zero_packet_owed = 1'b0;
            r.action = ACT_ZLP;
        end
        if (ctl.bytes_remaining == 8'd0 && !ctl.zero_packet_owed)
            ctl.awaiting_status = 1'b1;
    endfunction

    // Open a new IN data stage; an empty transfer owes one zero-length packet.
    function automatic void begin_transfer(input source_t src, input logic [2:0] str,
                                           input logic [7:0] size, inout ep0_result_t r);
        ctl.current_source   = src;
        ctl.current_string   = str;
        ctl.send_offset      = 8'd0;
        ctl.awaiting_status  = 1'b0;
        ctl.bytes_remaining  = size;
        ctl.zero_packet_owed = (size == 8'd0);
        arm_next_packet(r);
    endfunction

    function automatic void decode_setup(input ep0_item_t w, inout ep0_result_t r);
        logic [7:0] str_len;
        // Class requests to the interface: only SET_IDLE answers, state untouched
        if (w.request_type[6:0] == RTYPE_CLASS_IFACE)
        begin
            if (w.request_code == REQ_HID_SET_IDLE)
                r.action = ACT_ZLP;
            return;
        end
        case (w.request_code)
            REQ_GET_DESCRIPTOR:
            begin
                case (w.value_high)
                    DESC_DEVICE:
                        begin_transfer(SRC_DEVICE, 3'd0,
                                       fit_to_request(LEN_DEVICE, w.length_requested), r);
                    DESC_CONFIG:
                        begin_transfer(SRC_CONFIG, 3'd0,
                                       fit_to_request(LEN_CONFIG, w.length_requested), r);
                    DESC_STRING:
                    begin
                        if (w.value_low == 8'd0)
                        begin
                            begin_transfer(SRC_LANGUAGE, 3'd0,
                                           fit_to_request(LEN_LANGUAGE, w.length_requested), r);
                        end
                        else if (w.value_low <= STRING_COUNT)
                        begin
                            // String lengths are fixed; wLength is not applied here
                            case (w.value_low[2:0])
                                3'd1:       str_len = 8'd6;
                                3'd2:       str_len = 8'd20;
                                3'd3, 3'd4: str_len = 8'd32;
                                default:    str_len = 8'd12;
                            endcase
                            begin_transfer(SRC_STRING, w.value_low[2:0], str_len, r);
                        end
                        // Index past the table: drop silently
                    end
                    DESC_REPORT:
                        begin_transfer(SRC_REPORT, 3'd0,
                                       fit_to_request(report_len_model, w.length_requested), r);
                    default: ;
                endcase
            end
            REQ_SET_ADDRESS:
            begin
                ctl.stored_address  = w.value_low[6:0];
                ctl.address_pending = 1'b1;
                r.action = ACT_ZLP;
            end
            REQ_SET_CONFIGURATION:
            begin
                ctl.configuration_value = w.value_low[6:0];
                r.action = ACT_ZLP;
            end
            default: ;
        endcase
    endfunction

    // Advance the predicted state by one host event; return its result word.
    function automatic ep0_result_t ep0_respond(input ep0_item_t w);
        ep0_result_t r;
        r = '0;
        case (w.kind)
            KIND_SETUP:
                decode_setup(w, r);
            KIND_OUT_DONE:
            begin
                if (w.rx_size == 10'd0 && ctl.awaiting_status)
                begin
                    ctl.awaiting_status = 1'b0;
                    r.status_seen = 1'b1;
                end
            end
            KIND_IN_DONE:
            begin
                // Address takes effect once the SET_ADDRESS status IN completes
                if (ctl.address_pending)
                begin
                    ctl.address_pending = 1'b0;
                    r.apply_address = 1'b1;
                end
                arm_next_packet(r);
            end
            default:
            begin
                // Bus reset drops address and configuration, keeps any transfer
                ctl.address_pending     = 1'b0;
                ctl.stored_address      = 7'd0;
                ctl.configuration_value = 7'd0;
            end
        endcase
        r.device_address       = ctl.stored_address;
        r.active_configuration = ctl.configuration_value;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Host-side driver: bursts of words with random gaps between them.
    // Hold the payload while stalled; decide valid without looking at stall.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : host_driver
        ep0_item_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Word taken this edge: predict its reply and retire it
            if (in_valid && !in_stall)
            begin
                w = host_events_q.pop_front();
                expected_replies_q.push_back(ep0_respond(w));
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (host_events_q.size() != 0)
                begin
                    w = host_events_q[0];
                    in_valid         <= 1'b1;
                    kind             <= w.kind;
                    request_type     <= w.request_type;
                    request_code     <= w.request_code;
                    value_high       <= w.value_high;
                    value_low        <= w.value_low;
                    length_requested <= w.length_requested;
                    rx_size          <= w.rx_size;
                    // End of burst: pick the next burst and the gap before it
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side stall: switch between free-running, light random, heavy
    // random and periodic stalling.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_stall_gen
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 4) != 0);
            default: out_stall <= (stall_tick[2:1] == 2'b11);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : reply_monitor
        ep0_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, %s %0d",
                         $time, "actual action", action);
                errors++;
            end
            else
            begin
                want = expected_replies_q.pop_front();
                check_field("action", want.action, action);
                check_field("source", want.source, source);
                check_field("string_number", want.string_number, string_number);
                check_field("byte_offset", want.byte_offset, byte_offset);
                check_field("packet_length", want.packet_length, packet_length);
                check_field("apply_address", want.apply_address, apply_address);
                check_field("device_address", want.device_address, device_address);
                check_field("active_configuration", want.active_configuration,
                            active_configuration);
                check_field("status_seen", want.status_seen, status_seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    // Fully random word; the builders below override the fields that matter
    // so unused fields still toggle every bit.
    function automatic ep0_item_t noise_word();
        ep0_item_t w;
        w.kind             = kind_t'($urandom_range(0, 3));
        w.request_type     = 8'($urandom);
        w.request_code     = 8'($urandom);
        w.value_high       = 8'($urandom);
        w.value_low        = 8'($urandom);
        w.length_requested = 16'($urandom);
        w.rx_size          = 10'($urandom);
        return w;
    endfunction

    task automatic queue_setup(input logic [7:0] rtype, input logic [7:0] code,
                               input logic [7:0] vhi, input logic [7:0] vlo,
                               input logic [15:0] wlen);
        ep0_item_t w;
        w = noise_word();
        w.kind             = KIND_SETUP;
        w.request_type     = rtype;
        w.request_code     = code;
        w.value_high       = vhi;
        w.value_low        = vlo;
        w.length_requested = wlen;
        host_events_q.push_back(w);
    endtask

    task automatic queue_event(input kind_t k, input logic [9:0] rx);
        ep0_item_t w;
        w = noise_word();
        w.kind    = k;
        w.rx_size = rx;
        host_events_q.push_back(w);
    endtask

    // Mostly a device-to-host standard type; otherwise anything but a class
    // request to the interface.
    function automatic logic [7:0] host_rtype();
        logic [7:0] rt;
        if ($urandom_range(0, 3) != 0)
            return RT_DEV_TO_HOST;
        rt = 8'($urandom);
        if (rt[6:0] == RTYPE_CLASS_IFACE)
            rt[0] = ~rt[0];
        return rt;
    endfunction

    // wLength biased toward the packet-size and length boundaries
    function automatic logic [15:0] pick_wlength();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 8));
            2:       return 16'($urandom_range(PKT - 1, PKT + 1));
            3:       return 16'($urandom_range(2 * PKT - 1, 2 * PKT + 1));
            4:       return 16'hFFFF;
            5:       return 16'($urandom_range(255, 256));
            default: return 16'($urandom);
        endcase
    endfunction

    // Full control read: setup, a run of IN completions, then the OUT status.
    task automatic queue_descriptor_read();
        logic [7:0] dtype;
        logic [7:0] idx;
        int unsigned ins;
        idx = 8'd0;
        case ($urandom_range(0, 9))
            0:       dtype = DESC_DEVICE;
            1:       dtype = DESC_CONFIG;
            2:       dtype = DESC_STRING;
            3, 4:
            begin
                dtype = DESC_STRING;
                idx   = 8'($urandom_range(1, 5));
            end
            5, 6:    dtype = DESC_REPORT;
            7:
            begin
                dtype = DESC_STRING;
                idx   = 8'($urandom_range(6, 255));
            end
            8:       dtype = 8'($urandom);
            default:
            begin
                dtype = DESC_REPORT;
                idx   = 8'($urandom);
            end
        endcase
        queue_setup(host_rtype(), REQ_GET_DESCRIPTOR, dtype, idx, pick_wlength());
        ins = $urandom_range(0, 10);
        repeat (ins) queue_event(KIND_IN_DONE, 10'($urandom));
        if ($urandom_range(0, 3) != 0)
            queue_event(KIND_OUT_DONE, 10'd0);
        else
            queue_event(KIND_OUT_DONE, 10'($urandom));
    endtask

    // Mix of well-formed transfers (most of it), other requests and noise.
    task automatic queue_random_traffic(input int unsigned n);
        int unsigned target;
        int unsigned pick;
        target = host_events_q.size() + n;
        while (host_events_q.size() < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick <= 10)
            begin
                queue_descriptor_read();
            end
            else if (pick <= 12)
            begin
                queue_setup(RT_HOST_TO_DEV, REQ_SET_ADDRESS, 8'($urandom), 8'($urandom),
                            16'd0);
                queue_event(KIND_IN_DONE, 10'($urandom));
                if ($urandom_range(0, 1) == 0)
                    queue_event(KIND_OUT_DONE, 10'd0);
            end
            else if (pick == 13)
            begin
                queue_setup(RT_HOST_TO_DEV, REQ_SET_CONFIGURATION, 8'($urandom),
                            8'($urandom), 16'd0);
                queue_event(KIND_IN_DONE, 10'($urandom));
            end
            else if (pick == 14)
            begin
                // Class requests: SET_IDLE or some other code that gets dropped
                queue_setup(($urandom_range(0, 1) == 0) ? RT_CLASS_OUT : RT_CLASS_IN,
                            ($urandom_range(0, 2) != 0) ? REQ_HID_SET_IDLE : 8'($urandom),
                            8'($urandom), 8'($urandom), 16'($urandom));
            end
            else if (pick == 15)
            begin
                queue_event(KIND_BUS_RESET, 10'($urandom));
            end
            else if (pick <= 17)
            begin
                repeat ($urandom_range(1, 3)) host_events_q.push_back(noise_word());
            end
            else if (pick == 18)
            begin
                queue_event(KIND_OUT_DONE, ($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom));
            end
            else
            begin
                queue_event(KIND_IN_DONE, 10'($urandom));
            end
        end
    endtask

    // Wait for every queued word to go in and every reply to come back,
    // then let the two-stage pipeline settle.
    task automatic wait_for_idle();
        while (host_events_q.size() != 0 || expected_replies_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_report_length(input logic [7:0] len);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        report_len_model = len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned report_settings[$];
        report_settings = '{8'd0, 8'd255, 8'(PKT), 8'(2 * PKT), 8'd1, 8'(PKT + 1)};
        report_settings.push_back($urandom_range(0, 255));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, report length at its reset value
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'd0, 16'hFFFF);
        queue_event(KIND_OUT_DONE, 10'd0);           // status right after a short read
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_CONFIG, 8'd0, 16'(PKT));
        queue_event(KIND_IN_DONE, 10'd0);            // owed zero-length packet
        queue_event(KIND_IN_DONE, 10'd0);            // nothing left
        queue_event(KIND_OUT_DONE, 10'h3FF);         // not a status packet: drop
        queue_event(KIND_OUT_DONE, 10'd0);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 8'd0, 16'd2);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 8'd3, 16'd0);
        queue_event(KIND_IN_DONE, 10'd0);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 8'd6, 16'd64);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 8'hFF, 16'hFFFF);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, 8'hFF, 8'd0, 16'hFFFF);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_REPORT, 8'd0, 16'd0);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_REPORT, 8'd0, 16'hFFFF);
        queue_setup(RT_HOST_TO_DEV, REQ_SET_ADDRESS, 8'd0, 8'hFF, 16'd0);
        queue_event(KIND_IN_DONE, 10'd0);            // address applied here
        queue_setup(RT_HOST_TO_DEV, REQ_SET_CONFIGURATION, 8'd0, 8'h81, 16'd0);
        queue_setup(RT_CLASS_IN, REQ_HID_SET_IDLE, 8'd0, 8'd0, 16'd0);
        queue_setup(RT_CLASS_OUT, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'd0, 16'hFFFF);
        queue_setup(RT_DEV_TO_HOST, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 8'd5, 16'd1);
        queue_event(KIND_BUS_RESET, 10'h3FF);
        queue_setup(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_CONFIG, 8'd0, 16'hFFFF);
        queue_event(KIND_IN_DONE, 10'd0);            // tail chunk of a long read
        queue_event(KIND_IN_DONE, 10'd0);
        queue_random_traffic(160);
        wait_for_idle();

        // One phase per report length, extremes first
        foreach (report_settings[i])
        begin
            write_report_length(8'(report_settings[i]));
            queue_random_traffic(140);
            wait_for_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/uep0_pkg.sv
design/uep0_step.sv
design/usb_ep0_control_responder_core.sv
tb/sv/tb_usb_ep0_control_responder_core.sv
